### src/hbcvc_pkg.sv
`default_nettype none
package hbcvc_pkg;

    typedef struct packed {
        logic signed [11:0] coefficient;
        logic               first_of_block;
    } t_in_item;

    typedef struct packed {
        logic [19:0] code_value;
        logic [4:0]  code_length;
        logic        block_done;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CODE,
        ST_SEND,
        ST_EOB
    } t_state;

    localparam logic [1:0] CFG_QUANT     = 2'd0;
    localparam logic [1:0] CFG_QENABLE   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [19:0] EOB_CODE = 20'd2;
    localparam logic [4:0]  EOB_LEN  = 5'd2;
    localparam logic [4:0]  ESC_LEN  = 5'd20;
    localparam logic [5:0]  ESC_PREFIX = 6'b000001;

    // {length without sign, code}; length 0 means no entry
    function automatic logic [10:0] vlc_lookup(input logic [5:0] run, input logic [3:0] lvl);
        logic [10:0] r;
        r = 11'd0;
        unique case (run)
            6'd0: unique case (lvl)
                4'd1: r = {4'd2, 7'h03};   4'd2: r = {4'd4, 7'h04};
                4'd3: r = {4'd5, 7'h05};   4'd4: r = {4'd7, 7'h06};
                4'd5: r = {4'd8, 7'h26};   4'd6: r = {4'd8, 7'h21};
                4'd7: r = {4'd10, 7'h0A};  4'd8: r = {4'd12, 7'h1D};
                4'd9: r = {4'd12, 7'h18};  4'd10: r = {4'd12, 7'h13};
                4'd11: r = {4'd12, 7'h10}; 4'd12: r = {4'd13, 7'h1A};
                4'd13: r = {4'd13, 7'h19}; 4'd14: r = {4'd13, 7'h18};
                4'd15: r = {4'd13, 7'h17};
                default: r = 11'd0;
            endcase
            6'd1: unique case (lvl)
                4'd1: r = {4'd3, 7'h03};   4'd2: r = {4'd6, 7'h06};
                4'd3: r = {4'd8, 7'h25};   4'd4: r = {4'd10, 7'h0C};
                4'd5: r = {4'd12, 7'h1B};  4'd6: r = {4'd13, 7'h16};
                4'd7: r = {4'd13, 7'h15};
                default: r = 11'd0;
            endcase
            6'd2: unique case (lvl)
                4'd1: r = {4'd4, 7'h05};   4'd2: r = {4'd7, 7'h04};
                4'd3: r = {4'd10, 7'h0B};  4'd4: r = {4'd12, 7'h14};
                4'd5: r = {4'd13, 7'h14};
                default: r = 11'd0;
            endcase
            6'd3: unique case (lvl)
                4'd1: r = {4'd5, 7'h07};   4'd2: r = {4'd8, 7'h24};
                4'd3: r = {4'd12, 7'h1C};  4'd4: r = {4'd13, 7'h13};
                default: r = 11'd0;
            endcase
            6'd4: unique case (lvl)
                4'd1: r = {4'd5, 7'h06};   4'd2: r = {4'd10, 7'h0F};
                4'd3: r = {4'd12, 7'h12};
                default: r = 11'd0;
            endcase
            6'd5: unique case (lvl)
                4'd1: r = {4'd6, 7'h07};   4'd2: r = {4'd10, 7'h09};
                4'd3: r = {4'd13, 7'h12};
                default: r = 11'd0;
            endcase
            6'd6: if (lvl == 4'd1) r = {4'd6, 7'h05}; else if (lvl == 4'd2) r = {4'd12, 7'h1E};
            6'd7: if (lvl == 4'd1) r = {4'd6, 7'h04}; else if (lvl == 4'd2) r = {4'd12, 7'h15};
            6'd8: if (lvl == 4'd1) r = {4'd7, 7'h07}; else if (lvl == 4'd2) r = {4'd12, 7'h11};
            6'd9: if (lvl == 4'd1) r = {4'd7, 7'h05}; else if (lvl == 4'd2) r = {4'd13, 7'h11};
            6'd10: if (lvl == 4'd1) r = {4'd8, 7'h27}; else if (lvl == 4'd2) r = {4'd13, 7'h10};
            6'd11: if (lvl == 4'd1) r = {4'd8, 7'h23};
            6'd12: if (lvl == 4'd1) r = {4'd8, 7'h22};
            6'd13: if (lvl == 4'd1) r = {4'd8, 7'h20};
            6'd14: if (lvl == 4'd1) r = {4'd10, 7'h0E};
            6'd15: if (lvl == 4'd1) r = {4'd10, 7'h0D};
            6'd16: if (lvl == 4'd1) r = {4'd10, 7'h08};
            6'd17: if (lvl == 4'd1) r = {4'd12, 7'h1F};
            6'd18: if (lvl == 4'd1) r = {4'd12, 7'h1A};
            6'd19: if (lvl == 4'd1) r = {4'd12, 7'h19};
            6'd20: if (lvl == 4'd1) r = {4'd12, 7'h17};
            6'd21: if (lvl == 4'd1) r = {4'd12, 7'h16};
            6'd22: if (lvl == 4'd1) r = {4'd13, 7'h1F};
            6'd23: if (lvl == 4'd1) r = {4'd13, 7'h1E};
            6'd24: if (lvl == 4'd1) r = {4'd13, 7'h1D};
            6'd25: if (lvl == 4'd1) r = {4'd13, 7'h1C};
            6'd26: if (lvl == 4'd1) r = {4'd13, 7'h1B};
            default: r = 11'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### src/h261_block_coefficient_vlc_coder.sv
// channel | direction | handshake           | payload
// in      | input     | i_valid / o_ready   | i_in  (t_in_item)
// out     | output    | o_valid / i_ready   | o_out (t_out_item)
// cfg     | input     | i_cfg_we            | i_cfg_index, i_cfg_data
// with the sink ready, a dc item goes straight to the output register; an ac item whose
// level is zero passes ST_CODE only, one whose code is sent also passes ST_SEND, both after
// the restoring divider (ST_DIV) when quantizing; eob is sent from ST_EOB after the last coefficient.
// ready is low while an item is in work or a result waits in the output register;
// reset clears control state and loads the register reset values.
`default_nettype none
module h261_block_coefficient_vlc_coder
    import hbcvc_pkg::*;
#(
    parameter int FILTER_START = 20
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_in,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_out,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam logic [6:0] FILT_POS = 7'(FILTER_START);
    localparam logic [6:0] LAST_POS = 7'd63;

    t_state      r_state, n_state;
    logic [4:0]  r_quant;
    logic        r_qen;
    logic [7:0]  r_thr;
    logic [6:0]  r_pos, n_pos;
    logic [5:0]  r_run, n_run;
    logic        r_neg, n_neg;
    logic [10:0] r_quo, n_quo;     // magnitude, shifted into quotient
    logic [5:0]  r_rem, n_rem;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_eob, n_eob;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    logic [12:0] mag_in;
    logic [10:0] mag_sat;
    logic [12:0] dc_t;
    logic [7:0]  dc_code;
    logic [6:0]  trial;
    logic [7:0]  lvl_byte;
    logic [7:0]  lvl_abs;
    logic [10:0] hit;
    logic        lvl_zero;

    always_comb begin
        mag_in  = i_in.coefficient[11] ? 13'(-$signed({i_in.coefficient[11], i_in.coefficient}))
                                       : {1'b0, i_in.coefficient};
        mag_sat = mag_in[11] ? 11'd2047 : mag_in[10:0];
        dc_t    = 13'($signed({i_in.coefficient[11], i_in.coefficient}) + 13'sd4);
        if (dc_t[12] || dc_t[11:3] == 9'd0) dc_code = 8'd1;
        else if (dc_t[11:3] > 9'd254) dc_code = 8'd254;
        else if (dc_t[11:3] == 9'd128) dc_code = 8'd255;
        else dc_code = dc_t[10:3];
        trial    = {r_rem, r_quo[10]} - {1'b0, r_quant, 1'b0};
        lvl_zero = (r_quo == 11'd0) || (r_pos >= FILT_POS && r_quo <= {3'd0, r_thr});
        lvl_byte = lvl_zero ? 8'd0 : (r_neg ? 8'(-r_quo[7:0]) : r_quo[7:0]);
        lvl_abs  = lvl_byte[7] ? 8'(-lvl_byte) : lvl_byte;
        hit      = vlc_lookup(r_run, lvl_abs[3:0]);
    end

    always_comb begin
        n_state = r_state; n_pos = r_pos; n_run = r_run; n_neg = r_neg;
        n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt; n_eob = r_eob;
        n_ov = r_ov; n_out = r_out;
        o_ready = (r_state == ST_IDLE) && !r_ov;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    if (i_in.first_of_block) begin
                        n_out = '{code_value: {12'd0, dc_code}, code_length: 5'd8,
                                  block_done: 1'b0};
                        n_ov  = 1'b1;
                        n_pos = 7'd1;
                        n_run = 6'd0;
                    end else if (r_pos != 7'd0) begin
                        n_neg = i_in.coefficient[11];
                        n_quo = mag_sat;
                        n_rem = 6'd0;
                        n_cnt = 4'd0;
                        n_state = (r_qen && r_quant != 5'd0) ? ST_DIV : ST_CODE;
                    end
                end
            end
            ST_DIV: begin
                // one restoring step per cycle
                if (!trial[6]) begin
                    n_rem = trial[5:0];
                    n_quo = {r_quo[9:0], 1'b1};
                end else begin
                    n_rem = {r_rem[4:0], r_quo[10]};
                    n_quo = {r_quo[9:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd10) n_state = ST_CODE;
            end
            ST_CODE: begin
                n_eob = (r_pos == LAST_POS);
                n_pos = (r_pos == LAST_POS) ? 7'd0 : r_pos + 7'd1;
                if (lvl_byte != 8'd0) begin
                    if (lvl_abs <= 8'd15 && hit[10:7] != 4'd0)
                        n_out = '{code_value: {12'd0, hit[6:0], lvl_byte[7]},
                                  code_length: 5'(hit[10:7]) + 5'd1, block_done: 1'b0};
                    else
                        n_out = '{code_value: {ESC_PREFIX, r_run, lvl_byte},
                                  code_length: ESC_LEN, block_done: 1'b0};
                    n_run   = 6'd0;
                    n_state = ST_SEND;
                end else begin
                    n_run   = r_run + 6'd1;
                    n_state = (r_pos == LAST_POS) ? ST_EOB : ST_IDLE;
                end
            end
            ST_SEND: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_state = r_eob ? ST_EOB : ST_IDLE;
                end
            end
            ST_EOB: begin
                if (!r_ov) begin
                    n_out = '{code_value: EOB_CODE, code_length: EOB_LEN, block_done: 1'b1};
                    n_ov  = 1'b1;
                    n_run = 6'd0;
                    n_eob = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= 7'd0;
            r_run   <= 6'd0;
            r_eob   <= 1'b0;
            r_ov    <= 1'b0;
            r_quant <= 5'd10;
            r_qen   <= 1'b1;
            r_thr   <= 8'd0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_eob   <= n_eob;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_QUANT:     r_quant <= i_cfg_data[4:0];
                    CFG_QENABLE:   r_qen   <= i_cfg_data[0];
                    CFG_THRESHOLD: r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_out))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_ready)
        else $error("ready while an item is in work");
    a_eob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.block_done |-> r_pos == 7'd0)
        else $error("eob outside block end");
`endif

endmodule
`default_nettype wire

### bench/h261_block_coefficient_vlc_coder_tb.sv
`default_nettype none
module h261_block_coefficient_vlc_coder_tb;
    import hbcvc_pkg::*;

    localparam int BLOCK_LEN    = 64;
    localparam int FILTER_FROM  = 20;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_in;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    h261_block_coefficient_vlc_coder uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [4:0] mdl_quant;
    logic       mdl_qen;
    logic [7:0] mdl_thresh;
    int         mdl_pos;
    logic [5:0] mdl_run;

    t_out_item  codes_due[$];
    int         due_count;
    int         err_count;
    int         idle_sink;
    int         idle_src;
    int         stall_cycles;

    function automatic int vlc_entry(input int run, input int mag, output int len,
                                     output int bits);
        int k;
        int tbl[63][4] = '{
            '{0,1,2,'h03},'{0,2,4,'h04},'{0,3,5,'h05},'{0,4,7,'h06},'{0,5,8,'h26},
            '{0,6,8,'h21},'{0,7,10,'h0A},'{0,8,12,'h1D},'{0,9,12,'h18},'{0,10,12,'h13},
            '{0,11,12,'h10},'{0,12,13,'h1A},'{0,13,13,'h19},'{0,14,13,'h18},
            '{0,15,13,'h17},'{1,1,3,'h03},'{1,2,6,'h06},'{1,3,8,'h25},'{1,4,10,'h0C},
            '{1,5,12,'h1B},'{1,6,13,'h16},'{1,7,13,'h15},'{2,1,4,'h05},'{2,2,7,'h04},
            '{2,3,10,'h0B},'{2,4,12,'h14},'{2,5,13,'h14},'{3,1,5,'h07},'{3,2,8,'h24},
            '{3,3,12,'h1C},'{3,4,13,'h13},'{4,1,5,'h06},'{4,2,10,'h0F},'{4,3,12,'h12},
            '{5,1,6,'h07},'{5,2,10,'h09},'{5,3,13,'h12},'{6,1,6,'h05},'{6,2,12,'h1E},
            '{7,1,6,'h04},'{7,2,12,'h15},'{8,1,7,'h07},'{8,2,12,'h11},'{9,1,7,'h05},
            '{9,2,13,'h11},'{10,1,8,'h27},'{10,2,13,'h10},'{11,1,8,'h23},
            '{12,1,8,'h22},'{13,1,8,'h20},'{14,1,10,'h0E},'{15,1,10,'h0D},
            '{16,1,10,'h08},'{17,1,12,'h1F},'{18,1,12,'h1A},'{19,1,12,'h19},
            '{20,1,12,'h17},'{21,1,12,'h16},'{22,1,13,'h1F},'{23,1,13,'h1E},
            '{24,1,13,'h1D},'{25,1,13,'h1C},'{26,1,13,'h1B}};
        for (k = 0; k < 63; k++) begin
            if (tbl[k][0] == run && tbl[k][1] == mag) begin
                len = tbl[k][2];
                bits = tbl[k][3];
                return 1;
            end
        end
        return 0;
    endfunction

    task automatic predict_codes(input t_in_item it);
        int c;
        int t;
        int dc;
        int mag;
        int len;
        int bits;
        bit neg;
        logic [7:0] lvl;
        t_out_item r;
        c = it.coefficient;
        if (it.first_of_block) begin
            t = c + 4;
            if (t < 8) dc = 1;
            else begin
                dc = t >>> 3;
                if (dc > 254) dc = 254;
                else if (dc == 128) dc = 255;
            end
            r.code_value = 20'(dc);
            r.code_length = 5'd8;
            r.block_done = 1'b0;
            codes_due.push_back(r);
            due_count++;
            mdl_pos = 1;
            mdl_run = '0;
            return;
        end
        if (mdl_pos == 0 || mdl_pos >= BLOCK_LEN) begin
            mdl_pos = 0;
            return;
        end
        neg = c < 0;
        mag = neg ? -c : c;
        if (mag > 2047) mag = 2047;
        if (mdl_qen && mdl_quant != 0) mag = mag / (2 * mdl_quant);
        if (mdl_pos >= FILTER_FROM && mag <= mdl_thresh) mag = 0;
        lvl = neg ? 8'(-mag) : 8'(mag);
        if (lvl != 0) begin
            neg = lvl[7];
            mag = neg ? 256 - lvl : lvl;
            if (mag <= 15 && vlc_entry(mdl_run, mag, len, bits)) begin
                r.code_value = 20'((bits << 1) | neg);
                r.code_length = 5'(len + 1);
            end else begin
                r.code_value = {ESC_PREFIX, mdl_run, lvl};
                r.code_length = ESC_LEN;
            end
            r.block_done = 1'b0;
            codes_due.push_back(r);
            due_count++;
            mdl_run = '0;
        end else begin
            mdl_run = mdl_run + 6'd1;
        end
        mdl_pos++;
        if (mdl_pos >= BLOCK_LEN) begin
            r.code_value = EOB_CODE;
            r.code_length = EOB_LEN;
            r.block_done = 1'b1;
            codes_due.push_back(r);
            due_count++;
            mdl_pos = 0;
            mdl_run = '0;
        end
    endtask

    // output side
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (codes_due.size() == 0) begin
                $error("unexpected code %h len %0d", o_out.code_value, o_out.code_length);
                err_count++;
            end else begin
                want = codes_due.pop_front();
                if (o_out.code_value !== want.code_value) begin
                    $error("code_value exp %h got %h", want.code_value, o_out.code_value);
                    err_count++;
                end
                if (o_out.code_length !== want.code_length) begin
                    $error("code_length exp %0d got %0d", want.code_length,
                           o_out.code_length);
                    err_count++;
                end
                if (o_out.block_done !== want.block_done) begin
                    $error("block_done exp %0d got %0d", want.block_done,
                           o_out.block_done);
                    err_count++;
                end
            end
        end
        if (i_rst_n) i_ready <= ($urandom_range(99) >= idle_sink);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_QUANT:     mdl_quant = val[4:0];
            CFG_QENABLE:   mdl_qen = val[0];
            CFG_THRESHOLD: mdl_thresh = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (codes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // drives one item; returns at the edge it is accepted
    task automatic push_item(input logic signed [11:0] c, input logic first);
        t_in_item it;
        while ($urandom_range(99) < idle_src) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        it.coefficient = c;
        it.first_of_block = first;
        i_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_codes(it);
    endtask

    task automatic random_block(input int mode);
        int k;
        int lim;
        logic signed [11:0] c;
        lim = (mode == 0) ? $urandom_range(63, 20) : BLOCK_LEN;
        push_item(12'($urandom_range(4095)), 1'b1);
        for (k = 1; k < lim; k++) begin
            case ($urandom_range(4))
                0: c = 12'($urandom_range(4095));
                1: c = 12'sd0;
                2: c = 12'($signed($urandom_range(60)) - 30);
                3: c = $urandom_range(1) ? 12'sh800 : 12'sh7ff;
                default: c = 12'($signed($urandom_range(600)) - 300);
            endcase
            push_item(c, 1'b0);
        end
    endtask

    typedef struct {
        logic signed [11:0] coef;
        logic               first;
        logic               known;
        logic [19:0]        val;
        logic [4:0]         len;
    } t_row;

    t_row dir_rows[] = '{
        '{12'sh7ff, 1'b0, 1'b0, 20'd0, 5'd0},       // idle, ignored
        '{12'sh800, 1'b1, 1'b1, 20'd1, 5'd8},       // dc most negative
        '{12'sd1020, 1'b1, 1'b1, 20'd255, 5'd8},    // 128 maps to 255
        '{12'sd1028, 1'b1, 1'b1, 20'd129, 5'd8},
        '{12'sh7ff, 1'b1, 1'b1, 20'd254, 5'd8},     // dc clamp high
        '{12'sd20, 1'b0, 1'b1, 20'd6, 5'd3},        // level 1
        '{12'sh800, 1'b0, 1'b0, 20'd0, 5'd0},       // saturated
        '{-12'sd20, 1'b0, 1'b1, 20'd7, 5'd3},
        '{12'sd0, 1'b0, 1'b0, 20'd0, 5'd0},
        '{12'sd300, 1'b0, 1'b0, 20'd0, 5'd0},
        '{12'sd0, 1'b1, 1'b1, 20'd1, 5'd8}          // early restart
    };

    initial begin
        int k;
        int n;
        err_count = 0;
        due_count = 0;
        stall_cycles = 0;
        idle_sink = 37;
        idle_src = 37;
        mdl_quant = 5'd10;
        mdl_qen = 1'b1;
        mdl_thresh = 8'd0;
        mdl_pos = 0;
        mdl_run = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in <= '0;
        i_ready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_QUANT;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            n = due_count;
            push_item(dir_rows[k].coef, dir_rows[k].first);
            if (dir_rows[k].known && (due_count != n + 1 ||
                codes_due[$].code_value != dir_rows[k].val ||
                codes_due[$].code_length != dir_rows[k].len)) begin
                $error("row %0d table mismatch", k);
                err_count++;
            end
        end
        // finish a block through eob
        for (k = 1; k < BLOCK_LEN; k++) push_item(12'(k * 37 - 1000), 1'b0);
        i_valid <= 1'b0;
        wait_drained();

        write_reg(CFG_QENABLE, 8'd0);
        write_reg(CFG_THRESHOLD, 8'd255);
        random_block(1);
        i_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_QUANT, 8'd0);
        write_reg(CFG_QENABLE, 8'd1);
        write_reg(CFG_THRESHOLD, 8'd3);
        random_block(1);
        i_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_QUANT, 8'd31);
        write_reg(CFG_THRESHOLD, 8'd0);

        for (k = 0; k < 9; k++) begin
            if (k == 3) begin
                i_valid <= 1'b0;
                wait_drained();
                write_reg(CFG_QUANT, 8'd1);
                write_reg(CFG_QENABLE, 8'($urandom_range(1)));
                write_reg(CFG_THRESHOLD, 8'($urandom_range(6)));
            end
            if (k == 6) begin
                i_valid <= 1'b0;
                wait_drained();
                write_reg(CFG_QUANT, 8'($urandom_range(31, 1)));
                write_reg(CFG_QENABLE, 8'd1);
                write_reg(CFG_THRESHOLD, 8'd1);
                idle_sink = 0;
                idle_src = 0;
            end
            if (k == 8) begin
                idle_sink = 37;
                idle_src = 37;
            end
            random_block(k % 4 == 2 ? 0 : 1);
            if (k % 3 == 1) push_item(12'($urandom_range(4095)), 1'b0);
        end
        i_valid <= 1'b0;
        wait_drained();
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
src/hbcvc_pkg.sv
src/h261_block_coefficient_vlc_coder.sv
bench/h261_block_coefficient_vlc_coder_tb.sv
